// File: design/sps_pkg.sv
// shared types and constants for the stepper phase sequencer
package sps_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_PASS = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STEP_MODE  = 3'd0,
    CFG_STEP_DELAY = 3'd1,
    CFG_FULL_PAT   = 3'd2,
    CFG_HALF_PAT   = 3'd3,
    CFG_FULL_ANGLE = 3'd4,
    CFG_HALF_ANGLE = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // angle*256 + cycle/2 fits in 25 bits, so does the quotient
  localparam int QUOT_W     = 25;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic div_init;  // load dividend and divisor
    logic div_step;  // one restoring division step
    logic apply;     // update sequencer state and result
  } sps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // angle move while idle
  } sps_sts_t;

endpackage

// File: design/sps_ctrl.sv
// controller state machine: sequences capture, division and state update
module sps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sps_pkg::sps_cmd_t cmd,
  input  sps_pkg::sps_sts_t sts
);
  import sps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_APPLY
  } state_t;

  state_t                 state_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   out_valid_r;
  logic                   div_last;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign div_last  = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.div_init = (state_r == S_DECIDE) && sts.need_div;
    cmd.div_step = (state_r == S_DIV);
    cmd.apply    = ((state_r == S_DECIDE) && !sts.need_div) || (state_r == S_APPLY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sts.need_div) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (div_last) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/sps_datapath.sv
// datapath: config registers, pass-count divider and coil sequencing state
module sps_datapath #(
  parameter int PASS_COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                    in_func,
  input  logic                          in_direction,
  input  logic [15:0]                   in_angle_deg,
  input  sps_pkg::sps_cmd_t             cmd,
  output sps_pkg::sps_sts_t             sts,
  output logic [3:0]                    out_coils,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_rejected
);
  import sps_pkg::*;

  localparam int EXT_W = (PASS_COUNT_BITS > QUOT_W) ? PASS_COUNT_BITS : QUOT_W;
  localparam logic [PASS_COUNT_BITS-1:0] PASS_MASK = {PASS_COUNT_BITS{1'b1}};

  function automatic logic [3:0] pattern_at(input logic mode, input logic [2:0] idx,
                                            input logic [15:0] full_pat,
                                            input logic [31:0] half_pat);
    logic [3:0] nib;
    if (mode) begin
      nib = half_pat[{idx, 2'b00} +: 4];
    end else begin
      nib = full_pat[{idx[1:0], 2'b00} +: 4];
    end
    return nib;
  endfunction

  // configuration
  logic        step_mode_r;
  logic [7:0]  step_delay_r;
  logic [15:0] full_pat_r;
  logic [31:0] half_pat_r;
  logic [15:0] full_angle_r;
  logic [15:0] half_angle_r;

  // captured transaction
  logic [1:0]  func_r;
  logic        dir_r;
  logic [15:0] angle_r;

  // divider
  logic [QUOT_W-1:0] dvd_r;
  logic [15:0]       rem_r;
  logic [15:0]       dsr_r;
  logic              cyc_zero_r;
  logic [15:0]       cyc_sel;
  logic [16:0]       rem_sh;
  logic [17:0]       diff;

  // sequencer state
  logic [2:0]                 phase_r, phase_nxt;
  logic [PASS_COUNT_BITS-1:0] passes_r, passes_nxt;
  logic [7:0]                 hold_r, hold_nxt;
  logic                       running_r, running_nxt;
  logic                       mdir_r, mdir_nxt;
  logic                       mmode_r, mmode_nxt;
  logic [3:0]                 coil_r, coil_nxt;
  logic                       done_r, done_nxt;
  logic                       rej_r, rej_nxt;

  logic [EXT_W-1:0]           q_ext;
  logic [PASS_COUNT_BITS-1:0] n_div, n_sel, passes_dec;
  logic [7:0]                 hold_inc, delay;
  logic [2:0]                 last_idx, start_idx;
  logic                       pass_end;

  assign sts.need_div = (func_r == FUNC_MOVE) && !running_r;

  assign cyc_sel = step_mode_r ? half_angle_r : full_angle_r;
  assign rem_sh  = {rem_r, dvd_r[QUOT_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, dsr_r};

  assign q_ext = EXT_W'(dvd_r);
  assign n_div = (cyc_zero_r || (q_ext > EXT_W'(PASS_MASK))) ? PASS_MASK
               : q_ext[PASS_COUNT_BITS-1:0];
  assign n_sel = (func_r == FUNC_PASS) ? PASS_COUNT_BITS'(1) : n_div;

  always_comb begin
    phase_nxt   = phase_r;
    passes_nxt  = passes_r;
    hold_nxt    = hold_r;
    running_nxt = running_r;
    mdir_nxt    = mdir_r;
    mmode_nxt   = mmode_r;
    coil_nxt    = coil_r;
    done_nxt    = 1'b0;
    rej_nxt     = 1'b0;
    hold_inc    = hold_r + 8'd1;
    delay       = (step_delay_r == 8'd0) ? 8'd1 : step_delay_r;
    last_idx    = mmode_r ? 3'd7 : 3'd3;
    start_idx   = dir_r ? (step_mode_r ? 3'd7 : 3'd3) : 3'd0;
    pass_end    = mdir_r ? (phase_r == 3'd0) : (phase_r >= last_idx);
    passes_dec  = passes_r - 1'b1;
    case (func_r)
      FUNC_MOVE, FUNC_PASS: begin
        if (running_r) begin
          rej_nxt = 1'b1;
        end else if (n_sel == '0) begin
          done_nxt = 1'b1;
        end else begin
          mmode_nxt   = step_mode_r;
          mdir_nxt    = dir_r;
          passes_nxt  = n_sel;
          hold_nxt    = 8'd0;
          phase_nxt   = start_idx;
          coil_nxt    = pattern_at(step_mode_r, start_idx, full_pat_r, half_pat_r);
          running_nxt = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (running_r) begin
          if (hold_inc >= delay) begin
            hold_nxt = 8'd0;
            if (pass_end) begin
              passes_nxt = passes_dec;
              if (passes_dec == '0) begin
                running_nxt = 1'b0;
                done_nxt    = 1'b1;
              end else begin
                phase_nxt = mdir_r ? last_idx : 3'd0;
              end
            end else begin
              phase_nxt = mdir_r ? phase_r - 3'd1 : phase_r + 3'd1;
            end
            if (running_nxt) begin
              coil_nxt = pattern_at(mmode_r, phase_nxt, full_pat_r, half_pat_r);
            end
          end else begin
            hold_nxt = hold_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_mode_r  <= 1'b0;
      step_delay_r <= 8'd2;
      full_pat_r   <= 16'h8421;
      half_pat_r   <= 32'h98C46231;
      full_angle_r <= 16'd11520;
      half_angle_r <= 16'd11520;
      phase_r      <= '0;
      passes_r     <= '0;
      hold_r       <= '0;
      running_r    <= 1'b0;
      mdir_r       <= 1'b0;
      mmode_r      <= 1'b0;
      coil_r       <= '0;
      done_r       <= 1'b0;
      rej_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_MODE:  step_mode_r  <= cfg_wdata[0];
          CFG_STEP_DELAY: step_delay_r <= cfg_wdata[7:0];
          CFG_FULL_PAT:   full_pat_r   <= cfg_wdata[15:0];
          CFG_HALF_PAT:   half_pat_r   <= cfg_wdata[31:0];
          CFG_FULL_ANGLE: full_angle_r <= cfg_wdata[15:0];
          CFG_HALF_ANGLE: half_angle_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (cmd.apply) begin
        phase_r   <= phase_nxt;
        passes_r  <= passes_nxt;
        hold_r    <= hold_nxt;
        running_r <= running_nxt;
        mdir_r    <= mdir_nxt;
        mmode_r   <= mmode_nxt;
        coil_r    <= coil_nxt;
        done_r    <= done_nxt;
        rej_r     <= rej_nxt;
      end
    end
  end

  // transaction capture and restoring divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      dir_r   <= in_direction;
      angle_r <= in_angle_deg;
    end
    if (cmd.div_init) begin
      dvd_r      <= QUOT_W'({angle_r, 8'h00}) + QUOT_W'(cyc_sel[15:1]);
      rem_r      <= '0;
      dsr_r      <= cyc_sel;
      cyc_zero_r <= (cyc_sel == 16'd0);
    end else if (cmd.div_step) begin
      // quotient bits shift in where dividend bits leave
      if (!diff[17]) begin
        rem_r <= diff[15:0];
        dvd_r <= {dvd_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[15:0];
        dvd_r <= {dvd_r[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_coils    = coil_r;
  assign out_busy_res = running_r;
  assign out_done_res = done_r;
  assign out_rejected = rej_r;

endmodule

// File: design/stepper_phase_sequencer.sv
// top level: unipolar stepper full/half step phase sequencer
// sequencing: a tick, single-pass move, rejected move or unused code passes through the
//   decide state to its result; an angle move first runs the 25-step restoring division
//   of the pass count in the datapath, then the apply state, before its result
// flow: a new transaction is accepted only while idle and no result is held stalled
// reset: synchronous active-low rst_n restores register defaults, idles, coils off
module stepper_phase_sequencer #(
  parameter int PASS_COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic                          in_direction,
  input  logic [15:0]                   in_angle_deg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_coils,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic                          out_rejected
);
  import sps_pkg::*;

  sps_cmd_t cmd;
  sps_sts_t sts;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sps_datapath #(
    .PASS_COUNT_BITS (PASS_COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_func      (in_func),
    .in_direction (in_direction),
    .in_angle_deg (in_angle_deg),
    .cmd          (cmd),
    .sts          (sts),
    .out_coils    (out_coils),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rejected (out_rejected)
  );

endmodule

// File: design/sps_checker.sv
// port-level checks for the stepper phase sequencer, bound to the top level
module sps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_coils,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic       out_rejected
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coils)
      && $stable(out_busy_res) && $stable(out_done_res) && $stable(out_rejected))
    else $error("result changed while stalled");

  // a finished move leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_rejected)
    else $error("done reported while busy or rejected");

  // a move is only rejected while one is running
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("rejection while idle");

  // no result is shown in the cycle after an input transaction
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result valid too early");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (.*);
